// ===== design/ipc_pkg.sv =====
`default_nettype none

package ipc_pkg;

    // Operator stack sizing.
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    // Token queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Stream payload widths.
    localparam int VALUE_W   = 32;
    localparam int S_DATA_W  = 40;
    localparam int S_USER_W  = 3;
    localparam int M_DATA_W  = 40;
    localparam int M_USER_W  = 2;

    // Input token kinds.
    localparam logic [2:0] TOK_NUMBER = 3'd0;
    localparam logic [2:0] TOK_OPER   = 3'd1;
    localparam logic [2:0] TOK_OPEN   = 3'd2;
    localparam logic [2:0] TOK_CLOSE  = 3'd3;
    localparam logic [2:0] TOK_END    = 3'd4;

    // Operator codes, plus the stack marker for an open parenthesis.
    localparam logic [2:0] OP_PLUS   = 3'd0;
    localparam logic [2:0] OP_MINUS  = 3'd1;
    localparam logic [2:0] OP_TIMES  = 3'd2;
    localparam logic [2:0] OP_DIVIDE = 3'd3;
    localparam logic [2:0] OP_POWER  = 3'd4;
    localparam logic [2:0] OPEN_MARK = 3'd5;

    // Result kinds.
    localparam logic [1:0] OUT_NUMBER = 2'd0;
    localparam logic [1:0] OUT_OPER   = 2'd1;
    localparam logic [1:0] OUT_ERROR  = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNMATCHED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [1:0] ERR_OPEN_END  = 2'd3;

    // Precedence: plus and minus 1, times and divide 2, power 3.
    function automatic logic [1:0] prec_of(input logic [2:0] code);
        logic [1:0] p;
        if (code <= OP_MINUS) begin
            p = 2'd1;
        end else if (code <= OP_DIVIDE) begin
            p = 2'd2;
        end else begin
            p = 2'd3;
        end
        return p;
    endfunction

    // A classified token as it waits in the queue.
    typedef struct packed {
        logic [2:0]         kind;
        logic [2:0]         op;
        logic [1:0]         prec;
        logic [VALUE_W-1:0] value;
    } t_tok;

    // Status of the stack engine, watched at the top level.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             emit_err;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/infix_to_postfix_converter_top.sv =====
`default_nettype none

// Infix to postfix converter (shunting yard). Infix tokens enter on the slave
// stream and postfix tokens leave on the master stream; tlast marks the final
// beat caused by an input token, and tokens that cause nothing (an open
// parenthesis, a plain push) give no beat. A four-entry token queue decouples
// input from the stack engine. The engine works in steps on its single stack
// port: a number, a push or an open parenthesis is one step, an operator takes
// one step plus one per popped operator, and a close parenthesis or end of
// expression takes one step per popped operator plus a closing step that pops
// the open mark, ends the expression or gives the error. Each step emits at
// most one beat, so the output register paces the engine when the master side
// stalls. Errors (unmatched close, overflow of the 32-entry stack, open left
// at the end) give an error beat with tlast and empty the stack. Unknown token
// kinds and operator codes are accepted and dropped.
module infix_to_postfix_converter_top
    import ipc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,   // number_value[31:0], op_code[34:32], zeros
    input  wire logic [S_USER_W-1:0] i_s_tuser,   // token_kind[2:0]
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic [M_DATA_W-1:0]      o_m_tdata,   // out_value[31:0], out_op[34:32],
                                                  // error_code[36:35], zeros
    output logic [M_USER_W-1:0]      o_m_tuser,   // out_kind[1:0]
    output logic                     o_m_tlast
);

    logic               w_wr_valid;
    logic               w_wr_ready;
    t_tok               w_wr_data;
    logic               w_rd_valid;
    logic               w_rd_ready;
    t_tok               w_rd_data;
    logic [1:0]         w_kind;
    logic [VALUE_W-1:0] w_value;
    logic [2:0]         w_op;
    logic [1:0]         w_err;
    t_stat              w_stat;

    ipc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_wr_valid (w_wr_valid),
        .i_wr_ready (w_wr_ready),
        .o_wr_data  (w_wr_data)
    );

    ipc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_wr_valid),
        .o_wr_ready (w_wr_ready),
        .i_wr_data  (w_wr_data),
        .o_rd_valid (w_rd_valid),
        .i_rd_ready (w_rd_ready),
        .o_rd_data  (w_rd_data)
    );

    ipc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_valid (w_rd_valid),
        .o_rd_ready (w_rd_ready),
        .i_rd_data  (w_rd_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_kind     (w_kind),
        .o_value    (w_value),
        .o_op       (w_op),
        .o_err      (w_err),
        .o_last     (o_m_tlast),
        .o_stat     (w_stat)
    );

    // Pack the result fields onto the master stream.
    assign o_m_tdata = {3'b000, w_err, w_op, w_value};
    assign o_m_tuser = w_kind;

    // The stack never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= CNT_W'(STACK_DEPTH))
        else $error("operator stack count beyond depth");

    // Every error beat empties the stack.
    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.emit_err |=> (w_stat.count == '0))
        else $error("stack not cleared after error");

    // An error beat ends its token's run and carries a nonzero code.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_kind == OUT_ERROR)) |-> (o_m_tlast && (w_err != ERR_NONE)))
        else $error("error beat without tlast or code");

endmodule

`default_nettype wire

// ===== design/ipc_front.sv =====
`default_nettype none

module ipc_front
    import ipc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,   // number_value[31:0], op_code[34:32], zeros
    input  wire logic [S_USER_W-1:0] i_s_tuser,   // token_kind[2:0]
    output logic                     o_wr_valid,
    input  wire logic                i_wr_ready,
    output t_tok                     o_wr_data
);

    logic       w_known;
    logic [2:0] w_kind;
    logic [2:0] w_op;
    logic       r_seen;

    assign w_kind = i_s_tuser;
    assign w_op   = i_s_tdata[VALUE_W +: 3];

    // Tokens of an unknown kind or with an unknown operator are dropped.
    always_comb begin
        w_known = 1'b0;
        case (w_kind)
            TOK_NUMBER, TOK_OPEN, TOK_CLOSE, TOK_END: w_known = 1'b1;
            TOK_OPER: w_known = (w_op <= OP_POWER);
            default: w_known = 1'b0;
        endcase
    end

    // The front takes a beat whenever the queue has room, once r_seen is set after reset.
    assign o_s_tready = i_wr_ready && r_seen;
    assign o_wr_valid = i_s_tvalid && r_seen && w_known;

    always_comb begin
        o_wr_data.kind  = w_kind;
        o_wr_data.op    = w_op;
        o_wr_data.prec  = prec_of(w_op);
        o_wr_data.value = i_s_tdata[VALUE_W-1:0];
    end

    // Hold off input until the first cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== design/ipc_queue.sv =====
`default_nettype none

module ipc_queue
    import ipc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_valid,
    output logic      o_wr_ready,
    input  wire t_tok i_wr_data,
    output logic      o_rd_valid,
    input  wire logic i_rd_ready,
    output t_tok      o_rd_data
);

    t_tok               r_buf [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0] r_wr_ptr;
    logic [Q_IDX_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_wr;
    logic               w_rd;

    assign o_wr_ready = (r_cnt != Q_CNT_W'(QUEUE_DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_buf[r_rd_ptr];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_wr && w_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Token storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_buf[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/ipc_back.sv =====
`default_nettype none

module ipc_back
    import ipc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_rd_valid,
    output logic                    o_rd_ready,
    input  wire t_tok               i_rd_data,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [1:0]              o_kind,
    output logic [VALUE_W-1:0]      o_value,
    output logic [2:0]              o_op,
    output logic [1:0]              o_err,
    output logic                    o_last,
    output t_stat                   o_stat
);

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_PUSH  = 2'd1;
    localparam logic [1:0] ACT_POP   = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Stack below the top two entries; the top two entries live in their own
    // registers, so a pop refills the second entry with a clocked read.
    logic [2:0]         r_stack [STACK_DEPTH];
    logic [2:0]         r_top;
    logic [2:0]         r_second;
    logic [CNT_W-1:0]   r_count;

    logic               r_valid;
    logic [1:0]         r_kind;
    logic [VALUE_W-1:0] r_value;
    logic [2:0]         r_op;
    logic [1:0]         r_err;
    logic               r_last;

    logic               w_free;
    logic               w_go;
    logic               w_has;
    logic               w_has2;
    logic               w_full;
    logic [CNT_W-1:0]   w_cnt_m1;
    logic [CNT_W-1:0]   w_cnt_m2;
    logic [CNT_W-1:0]   w_cnt_m3;
    logic [2:0]         w_second;
    logic               w_top_pops;
    logic               w_second_pops;

    logic [1:0]         n_act;
    logic [2:0]         n_push_val;
    logic               n_emit;
    logic               n_done;
    logic [1:0]         n_kind;
    logic [VALUE_W-1:0] n_value;
    logic [2:0]         n_op;
    logic [1:0]         n_err;
    logic               n_last;

    assign w_free   = !r_valid || i_m_tready;
    assign w_go     = i_rd_valid && w_free;
    assign w_has    = (r_count != '0);
    assign w_has2   = (r_count > CNT_W'(1));
    assign w_full   = (r_count >= CNT_W'(STACK_DEPTH));
    assign w_cnt_m1 = r_count - 1'b1;
    assign w_cnt_m2 = r_count - CNT_W'(2);
    assign w_cnt_m3 = r_count - CNT_W'(3);
    assign w_second = r_second;

    // An operator pops a stacked operator of greater or equal precedence.
    assign w_top_pops    = w_has && (r_top != OPEN_MARK) &&
                           (prec_of(r_top) >= i_rd_data.prec);
    assign w_second_pops = w_has2 && (w_second != OPEN_MARK) &&
                           (prec_of(w_second) >= i_rd_data.prec);

    // One step of the token at the head of the queue.
    always_comb begin
        n_act      = ACT_NONE;
        n_push_val = i_rd_data.op;
        n_emit     = 1'b0;
        n_done     = 1'b1;
        n_kind     = OUT_OPER;
        n_value    = '0;
        n_op       = r_top;
        n_err      = ERR_NONE;
        n_last     = 1'b1;
        case (i_rd_data.kind)
            TOK_NUMBER: begin
                n_emit  = 1'b1;
                n_kind  = OUT_NUMBER;
                n_value = i_rd_data.value;
                n_op    = '0;
            end
            TOK_OPER: begin
                if (w_top_pops) begin
                    n_act  = ACT_POP;
                    n_emit = 1'b1;
                    n_done = 1'b0;
                    n_last = !w_second_pops;
                end else if (w_full) begin
                    n_act  = ACT_CLEAR;
                    n_emit = 1'b1;
                    n_kind = OUT_ERROR;
                    n_op   = '0;
                    n_err  = ERR_OVERFLOW;
                end else begin
                    n_act = ACT_PUSH;
                end
            end
            TOK_OPEN: begin
                n_push_val = OPEN_MARK;
                if (w_full) begin
                    n_act  = ACT_CLEAR;
                    n_emit = 1'b1;
                    n_kind = OUT_ERROR;
                    n_op   = '0;
                    n_err  = ERR_OVERFLOW;
                end else begin
                    n_act = ACT_PUSH;
                end
            end
            TOK_CLOSE: begin
                if (w_has && (r_top != OPEN_MARK)) begin
                    // The beat is last when the matching open comes next.
                    n_act  = ACT_POP;
                    n_emit = 1'b1;
                    n_done = 1'b0;
                    n_last = w_has2 && (w_second == OPEN_MARK);
                end else if (w_has) begin
                    n_act = ACT_POP;
                end else begin
                    n_act  = ACT_CLEAR;
                    n_emit = 1'b1;
                    n_kind = OUT_ERROR;
                    n_op   = '0;
                    n_err  = ERR_UNMATCHED;
                end
            end
            TOK_END: begin
                if (w_has && (r_top != OPEN_MARK)) begin
                    // The beat is last when it empties the stack.
                    n_act  = ACT_POP;
                    n_emit = 1'b1;
                    n_done = 1'b0;
                    n_last = !w_has2;
                end else if (w_has) begin
                    n_act  = ACT_CLEAR;
                    n_emit = 1'b1;
                    n_kind = OUT_ERROR;
                    n_op   = '0;
                    n_err  = ERR_OPEN_END;
                end
            end
            default: begin
                n_act = ACT_NONE;
            end
        endcase
    end

    assign o_rd_ready = w_go && n_done;

    // Stack pointer (entry count).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_go) begin
            case (n_act)
                ACT_PUSH:  r_count <= r_count + 1'b1;
                ACT_POP:   r_count <= w_cnt_m1;
                ACT_CLEAR: r_count <= '0;
                default:   r_count <= r_count;
            endcase
        end
    end

    // A push spills the second entry into the array; a pop reads it back.
    always_ff @(posedge i_clk) begin
        if (w_go && (n_act == ACT_PUSH)) begin
            r_top    <= n_push_val;
            r_second <= r_top;
            if (w_has2) begin
                r_stack[w_cnt_m2[IDX_W-1:0]] <= r_second;
            end
        end else if (w_go && (n_act == ACT_POP)) begin
            r_top    <= r_second;
            r_second <= r_stack[w_cnt_m3[IDX_W-1:0]];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_go && n_emit) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && n_emit) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_op    <= n_op;
            r_err   <= n_err;
            r_last  <= n_last;
        end
    end

    assign o_m_tvalid      = r_valid;
    assign o_kind          = r_kind;
    assign o_value         = r_value;
    assign o_op            = r_op;
    assign o_err           = r_err;
    assign o_last          = r_last;
    assign o_stat.count    = r_count;
    assign o_stat.emit_err = w_go && n_emit && (n_kind == OUT_ERROR);

endmodule

`default_nettype wire
